// File: src/tile_scroll_exposed_rectangles_core_macros.svh
// ----------------------------------------------------------------------------
// tile scroll exposed rectangles - assertion macros
// shared concurrent assertion forms for the core
// ----------------------------------------------------------------------------
`ifndef TILE_SCROLL_EXPOSED_RECTANGLES_CORE_MACROS_SVH
`define TILE_SCROLL_EXPOSED_RECTANGLES_CORE_MACROS_SVH

// same-cycle implication
`define TSER_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TSER_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/tser_pkg.sv
// ----------------------------------------------------------------------------
// tser_pkg
// types and constants of the tile scroll exposed rectangles core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tser_pkg;

   localparam int SCREEN_WIDTH  = 240;
   localparam int SCREEN_HEIGHT = 160;
   localparam int TILE_SHIFT    = 3;

   localparam int POS_W  = 13;
   localparam int TILE_W = 11;
   localparam int MC_W   = 11;
   localparam int SRC_W  = 20;
   localparam int RING_W = 5;
   localparam int SIZE_W = 6;
   localparam int OFS_W  = 8;

   localparam logic OP_SCROLL   = 1'b0;
   localparam logic OP_REDRAW   = 1'b1;
   localparam logic KIND_COPY   = 1'b0;
   localparam logic KIND_OFFSET = 1'b1;

   localparam logic [1:0] REG_DYNAMIC_MODE = 2'd0;
   localparam logic [1:0] REG_ATTACHED     = 2'd1;
   localparam logic [1:0] REG_MAP_COLUMNS  = 2'd2;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [TILE_W-1:0] tile_type;

   typedef struct packed {
      logic              kind;
      logic [SRC_W-1:0]  source_offset;
      logic [RING_W-1:0] ring_x;
      logic [RING_W-1:0] ring_y;
      logic [SIZE_W-1:0] rect_width;
      logic [SIZE_W-1:0] rect_height;
      logic              indirect;
      logic [OFS_W-1:0]  offset_x;
      logic [OFS_W-1:0]  offset_y;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    rsp;
   } calc_type;

endpackage

// File: src/tser_calc.sv
// ----------------------------------------------------------------------------
// tser_calc
// builds result number index of one scroll or redraw item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tser_calc (
   input  logic                  op,
   input  tser_pkg::pos_type     new_x,
   input  tser_pkg::pos_type     new_y,
   input  tser_pkg::pos_type     saved_x,
   input  tser_pkg::pos_type     saved_y,
   input  logic                  attached,
   input  logic                  dynamic_mode,
   input  logic [tser_pkg::MC_W-1:0] map_columns,
   input  logic [1:0]            index,
   output tser_pkg::calc_type    calc
);
   import tser_pkg::*;

   logic [POS_W:0] ox_sum, oy_sum, nx_sum, ny_sum;
   tile_type ol, ot, orr, ob, nl, nt, nr, nb;
   tile_type top, bot;
   tile_type x0, y0, x1, y1;
   tile_type span_w, span_h;
   logic apart, h_down, h_up, h_en, v_right, v_left, v_en;
   logic [1:0] ncopy;
   logic [2*TILE_W-1:0] prod;
   logic [2*TILE_W-1:0] src_sum;
   pos_type ofs_x, ofs_y;
   rsp_type r;

   always_comb begin
      ox_sum = {1'b0, saved_x} + (POS_W+1)'(SCREEN_WIDTH - 1);
      oy_sum = {1'b0, saved_y} + (POS_W+1)'(SCREEN_HEIGHT - 1);
      nx_sum = {1'b0, new_x} + (POS_W+1)'(SCREEN_WIDTH - 1);
      ny_sum = {1'b0, new_y} + (POS_W+1)'(SCREEN_HEIGHT - 1);
      ol  = TILE_W'(saved_x >> TILE_SHIFT);
      ot  = TILE_W'(saved_y >> TILE_SHIFT);
      orr = TILE_W'(ox_sum >> TILE_SHIFT);
      ob  = TILE_W'(oy_sum >> TILE_SHIFT);
      nl  = TILE_W'(new_x >> TILE_SHIFT);
      nt  = TILE_W'(new_y >> TILE_SHIFT);
      nr  = TILE_W'(nx_sum >> TILE_SHIFT);
      nb  = TILE_W'(ny_sum >> TILE_SHIFT);

      apart = (ot < nt && ob <= nt) || (ot >= nb && ob > nb) ||
              (ol < nl && orr <= nl) || (ol >= nr && orr > nr);
      h_down  = nb > ob;
      h_up    = nt < ot;
      h_en    = h_down || h_up;
      v_right = nr > orr;
      v_left  = nl < ol;
      v_en    = v_right || v_left;
      top = (ot > nt) ? ot : nt;
      bot = (ob < nb) ? ob : nb;

      if (op == OP_REDRAW || apart) begin
         ncopy = 2'd1;
      end else begin
         ncopy = {1'b0, h_en} + {1'b0, v_en};
      end

      // rectangle picked by index
      if (op == OP_REDRAW) begin
         x0 = ol; y0 = ot; x1 = orr; y1 = ob;
      end else if (apart) begin
         x0 = nl; y0 = nt; x1 = nr; y1 = nb;
      end else if (index == 2'd0 && h_en) begin
         x0 = nl;
         x1 = nr;
         if (h_down) begin
            y0 = ob + TILE_W'(1);
            y1 = nb;
         end else begin
            y0 = nt;
            y1 = ot - TILE_W'(1);
         end
      end else begin
         y0 = top;
         y1 = bot;
         if (v_right) begin
            x0 = orr + TILE_W'(1);
            x1 = nr;
         end else begin
            x0 = nl;
            x1 = ol - TILE_W'(1);
         end
      end

      span_w  = x1 - x0 + TILE_W'(1);
      span_h  = y1 - y0 + TILE_W'(1);
      prod    = (2*TILE_W)'(y0) * (2*TILE_W)'(map_columns);
      src_sum = prod + (2*TILE_W)'(x0);
      ofs_x   = (op == OP_REDRAW) ? saved_x : new_x;
      ofs_y   = (op == OP_REDRAW) ? saved_y : new_y;

      r = '0;
      if (index == ncopy) begin
         r.kind     = KIND_OFFSET;
         r.offset_x = ofs_x[OFS_W-1:0];
         r.offset_y = ofs_y[OFS_W-1:0];
         r.last     = 1'b1;
      end else begin
         r.kind          = KIND_COPY;
         r.source_offset = src_sum[SRC_W-1:0];
         r.ring_x        = x0[RING_W-1:0];
         r.ring_y        = y0[RING_W-1:0];
         r.rect_width    = span_w[SIZE_W-1:0];
         r.rect_height   = span_h[SIZE_W-1:0];
         r.indirect      = dynamic_mode;
      end

      calc.count = attached ? (ncopy + 2'd1) : 2'd0;
      calc.rsp   = r;
   end

endmodule

// File: src/tile_scroll_exposed_rectangles_core.sv
// ----------------------------------------------------------------------------
// tile_scroll_exposed_rectangles_core
// scroll tracker for a screen window over a tile map, emits copy commands
// for exposed tiles and a display offset update
// ----------------------------------------------------------------------------
// channel | ports | transfer when
// req     | req_valid, req_stall, req_opcode, req_scroll_x/y | valid and !stall
// rsp     | rsp_valid, rsp_stall, rsp_kind ... rsp_last      | valid and !stall
// csr     | csr_psel ... csr_pready, 32 bit apb style        | psel, penable, pwrite
//
// an item sits in the input register and sends one result a cycle into the
// output register while it is free: 1 to 3 results per item, none if not attached
// a new item is taken in the cycle its last result moves into the output register
// a stalled output holds and backs up into req_stall
// synchronous reset clears valids, result index, saved position and config registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tile_scroll_exposed_rectangles_core_macros.svh"

module tile_scroll_exposed_rectangles_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_opcode,
   input  logic [12:0]                 req_scroll_x,
   input  logic [12:0]                 req_scroll_y,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_kind,
   output logic [19:0]                 rsp_source_offset,
   output logic [4:0]                  rsp_ring_x,
   output logic [4:0]                  rsp_ring_y,
   output logic [5:0]                  rsp_rect_width,
   output logic [5:0]                  rsp_rect_height,
   output logic                        rsp_indirect,
   output logic [7:0]                  rsp_offset_x,
   output logic [7:0]                  rsp_offset_y,
   output logic                        rsp_last,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [3:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import tser_pkg::*;

   logic              dynamic_mode_ff, attached_ff;
   logic [MC_W-1:0]   map_columns_ff;
   pos_type           saved_x_ff, saved_y_ff;
   logic              item_valid_ff;
   logic              op_ff;
   pos_type           x_ff, y_ff;
   logic [1:0]        seq_ff, seq_in;
   logic              out_valid_ff;
   rsp_type           out_ff;
   calc_type          calc;
   logic              out_free, load, done, accept, csr_write;

   tser_calc u_calc (
      .op           (op_ff),
      .new_x        (x_ff),
      .new_y        (y_ff),
      .saved_x      (saved_x_ff),
      .saved_y      (saved_y_ff),
      .attached     (attached_ff),
      .dynamic_mode (dynamic_mode_ff),
      .map_columns  (map_columns_ff),
      .index        (seq_ff),
      .calc         (calc)
   );

   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      load      = item_valid_ff && calc.count != 2'd0 && out_free;
      done      = item_valid_ff &&
                  (calc.count == 2'd0 || (out_free && seq_ff == calc.count - 2'd1));
      req_stall = item_valid_ff && !done;
      accept    = req_valid && !req_stall;
      seq_in    = done ? 2'd0 : (load ? seq_ff + 2'd1 : seq_ff);
      csr_write = csr_psel && csr_penable && csr_pwrite;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         seq_ff        <= 2'd0;
         out_valid_ff  <= 1'b0;
         saved_x_ff    <= '0;
         saved_y_ff    <= '0;
      end else begin
         seq_ff <= seq_in;
         if (accept) begin
            item_valid_ff <= 1'b1;
         end else if (done) begin
            item_valid_ff <= 1'b0;
         end
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (done && op_ff == OP_SCROLL) begin
            saved_x_ff <= x_ff;
            saved_y_ff <= y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_opcode;
         x_ff  <= req_scroll_x;
         y_ff  <= req_scroll_y;
      end
      if (load) begin
         out_ff <= calc.rsp;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dynamic_mode_ff <= 1'b0;
         attached_ff     <= 1'b0;
         map_columns_ff  <= MC_W'(32);
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_DYNAMIC_MODE: dynamic_mode_ff <= csr_pwdata[0];
            REG_ATTACHED:     attached_ff     <= csr_pwdata[0];
            REG_MAP_COLUMNS:  map_columns_ff  <= csr_pwdata[MC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_DYNAMIC_MODE: csr_prdata = {31'd0, dynamic_mode_ff};
         REG_ATTACHED:     csr_prdata = {31'd0, attached_ff};
         REG_MAP_COLUMNS:  csr_prdata = {{(32-MC_W){1'b0}}, map_columns_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign csr_pready        = 1'b1;
   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_ff.kind;
   assign rsp_source_offset = out_ff.source_offset;
   assign rsp_ring_x        = out_ff.ring_x;
   assign rsp_ring_y        = out_ff.ring_y;
   assign rsp_rect_width    = out_ff.rect_width;
   assign rsp_rect_height   = out_ff.rect_height;
   assign rsp_indirect      = out_ff.indirect;
   assign rsp_offset_x      = out_ff.offset_x;
   assign rsp_offset_y      = out_ff.offset_y;
   assign rsp_last          = out_ff.last;

   `TSER_ASSERT_NOW(a_offset_is_last, clock, reset, rsp_valid && rsp_kind == KIND_OFFSET, rsp_last, "offset result without last")
   `TSER_ASSERT_NOW(a_seq_idle_zero, clock, reset, !item_valid_ff, seq_ff == 2'd0, "result index left over")
   `TSER_ASSERT_NEXT(a_accept_holds, clock, reset, req_valid && !req_stall, item_valid_ff, "accepted item lost")

endmodule
